[rtl/core/cla_pkg.sv]
// Shared types and character codes for the command line assembler.
package cla_pkg;

   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;

   localparam logic       OP_BYTE = 1'b0;
   localparam logic       OP_TICK = 1'b1;

   localparam logic [15:0] IDLE_MAX         = 16'hFFFF;
   localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;
   localparam logic        REG_IDLE_TIMEOUT = 1'b0;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       store_valid;
      logic [5:0] store_index;
      logic [7:0] store_char;
      logic       message_done;
      logic [5:0] message_length;
      logic       timed_out;
   } rsp_type;

endpackage

[rtl/core/command_line_assembler_core.sv]
// Command line assembler: one byte or tick beat in, one result beat out.
//
// Takes one beat per cycle while not stalled and returns exactly one result beat
// per accepted beat, in the next cycle, from a single output register; a new beat
// is accepted while that register is empty or being drained in the same cycle, so
// throughput is one beat per clock. Cost per beat is one pass of character
// classification and the length/idle counter update between the state registers
// and the output register. The idle timeout register sits at byte address 0 of the
// csr port (bit 2 of the address selects it, only the low 16 bits of data are kept).
module command_line_assembler_core #(
   parameter int MSG_CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cla_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cla_pkg::rsp_type    rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int LEN_W = $clog2(MSG_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MSG_CAPACITY - 1);

   logic [LEN_W-1:0]  len_ff, len_in;
   logic              lws_ff, lws_in;
   logic [15:0]       idle_ff, idle_in;
   logic [15:0]       timeout_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   cla_pkg::rsp_type  rsp_data_ff, rsp_data_in, result;

   logic              accept;
   logic              cfg_write;
   logic [7:0]        ch;
   logic              is_space;
   logic              keep;
   logic [LEN_W-1:0]  base_len;
   logic [LEN_W-1:0]  next_len;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[2] == cla_pkg::REG_IDLE_TIMEOUT);
   assign csr_prdata = (csr_paddr[2] == cla_pkg::REG_IDLE_TIMEOUT) ?
                       {16'd0, timeout_ff} : 32'd0;

   always_comb begin
      ch       = req_data.rx_byte;
      if (ch == cla_pkg::CH_TAB || ch == cla_pkg::CH_LF) begin
         ch = cla_pkg::CH_SPACE;
      end
      is_space = (ch == cla_pkg::CH_SPACE);
      keep     = ~(is_space && (len_ff == '0 || lws_ff));
      base_len = (ch == cla_pkg::CH_LBRACKET) ? '0 : len_ff;
      next_len = base_len + LEN_W'(1);

      len_in  = len_ff;
      lws_in  = lws_ff;
      idle_in = idle_ff;
      result  = '0;

      if (req_data.op == cla_pkg::OP_TICK) begin
         if (idle_ff != cla_pkg::IDLE_MAX) begin
            idle_in = idle_ff + 16'd1;
         end
         if (len_ff != '0 && idle_in >= timeout_ff) begin
            len_in           = '0;
            lws_in           = 1'b0;
            result.timed_out = 1'b1;
         end
      end else begin
         idle_in = '0;
         if (req_data.rx_byte == cla_pkg::CH_CR || req_data.rx_byte == cla_pkg::CH_SEMI) begin
            result.message_done   = 1'b1;
            result.message_length = 6'(len_ff);
            len_in                = '0;
            lws_in                = 1'b0;
         end else if (keep) begin
            len_in = base_len;
            if (ch == cla_pkg::CH_LBRACKET) begin
               lws_in = 1'b0;
            end
            if (base_len < LEN_LIMIT) begin
               result.store_valid = 1'b1;
               result.store_index = 6'(base_len);
               result.store_char  = ch;
               len_in             = next_len;
               lws_in             = is_space;
               // closing bracket is stored, then ends the message
               if (ch == cla_pkg::CH_RBRACKET) begin
                  result.message_done   = 1'b1;
                  result.message_length = 6'(next_len);
                  len_in                = '0;
                  lws_in                = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         lws_ff       <= 1'b0;
         idle_ff      <= '0;
         timeout_ff   <= cla_pkg::TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            len_ff  <= len_in;
            lws_ff  <= lws_in;
            idle_ff <= idle_in;
         end
         if (cfg_write) begin
            timeout_ff <= csr_pwdata[15:0];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/core/cla_checker.sv]
// Port-level checks for the command line assembler, bound to the top level.
module cla_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input cla_pkg::req_type  req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cla_pkg::rsp_type  rsp_data
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted beat gave no result");

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.timed_out |-> !rsp_data.store_valid && !rsp_data.message_done)
      else $error("timeout mixed with store or end");

   // a message ending on a stored character must be a closing bracket
   a_bracket_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.store_valid && rsp_data.message_done |->
         rsp_data.store_char == cla_pkg::CH_RBRACKET &&
         rsp_data.message_length == rsp_data.store_index + 6'd1)
      else $error("bad end on stored character");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind command_line_assembler_core cla_checker u_cla_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
